/* rtl/tspu_pkg.sv */
// Shared constants for the two-stage phase unwrap unit.
package tspu_pkg;

    // Default parameter values.
    localparam int FRACTION_BITS_DEF = 7;
    localparam int ACC_WIDTH_DEF     = 32;

    // Fixed field widths of the stream and configuration ports.
    localparam int PHASE_W    = 16;
    localparam int OUT_W      = 32;
    localparam int COARSE_W   = 16;
    localparam int FINE_W     = 15;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 16;

    // Turn sizes in whole degrees.
    localparam int DEG_FULL = 360;
    localparam int DEG_HALF = 180;

    // Threshold values after reset (degrees times 128).
    localparam logic [COARSE_W-1:0] COARSE_RST = 16'd34560;
    localparam logic [FINE_W-1:0]   FINE_RST   = 15'd11520;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] REG_COARSE = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_FINE   = 1'b1;

endpackage

/* rtl/two_stage_phase_unwrap_unit.sv */
// Top level of the two-stage phase unwrap unit.
//
//  channel   | direction | handshake               | payload
//  ----------+-----------+-------------------------+-----------------------------------------
//  s stream  | in        | i_s_tvalid / o_s_tready | tdata: phase_degrees; tuser: first_sample
//  m stream  | out       | o_m_tvalid / i_m_tready | tdata: unwrapped_phase, coarse_unwrapped
//  cfg write | in        | i_cfg_we                | i_cfg_addr index, i_cfg_wdata value
//
// One transaction is taken per clock cycle when the output side keeps up.
// A sample is first captured in the input register; the mirror, the
// coarse stage and the fine stage then run in a single combinational pass
// into the result register, from which the result is offered.
// The rate is set by the feedback of the stored previous coarse and fine values,
// which are updated in the same cycle as the result register.
// Reset is synchronous and active low; it clears the valid flags and the
// stored history and loads the default thresholds.
// When the output is stalled, the input register still accepts one more
// transaction, and then the input side stalls too.
module two_stage_phase_unwrap_unit #(
    parameter int FRACTION_BITS = tspu_pkg::FRACTION_BITS_DEF,
    parameter int ACC_WIDTH     = tspu_pkg::ACC_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Input stream.
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [tspu_pkg::PHASE_W-1:0]    i_s_tdata,   // [15:0] phase_degrees
    input  logic                            i_s_tuser,   // [0] first_sample
    // Output stream.
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [2*tspu_pkg::OUT_W-1:0]    o_m_tdata,   // [31:0] unwrapped_phase,
                                                         // [63:32] coarse_unwrapped
    // Configuration write port.
    input  logic                            i_cfg_we,
    input  logic [tspu_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [tspu_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);

    // Fixed-point turn sizes and internal widths. The working width covers
    // the accumulator, the mirrored sample and the output word, plus headroom
    // for a step and a turn correction.
    localparam int FULL_TURN = tspu_pkg::DEG_FULL << FRACTION_BITS;
    localparam int HALF_TURN = tspu_pkg::DEG_HALF << FRACTION_BITS;
    localparam int MIR_W     = $clog2(FULL_TURN + 1);
    localparam int ACC_OUT_W = (ACC_WIDTH > tspu_pkg::OUT_W) ? ACC_WIDTH : tspu_pkg::OUT_W;
    localparam int BASE_W    = (ACC_OUT_W > MIR_W) ? ACC_OUT_W : MIR_W;
    localparam int WIDE_W    = ((BASE_W > tspu_pkg::COARSE_W + 1) ?
                                BASE_W : tspu_pkg::COARSE_W + 1) + 4;
    localparam int OUT_W     = tspu_pkg::OUT_W;

    localparam logic signed [WIDE_W-1:0] FULL_V    = WIDE_W'(FULL_TURN);
    localparam logic signed [WIDE_W-1:0] HALF_V    = WIDE_W'(HALF_TURN);
    localparam logic signed [WIDE_W-1:0] PHASE_MAX = WIDE_W'(FULL_TURN - 1);

    // Input register.
    logic                         r_in_valid;
    logic [tspu_pkg::PHASE_W-1:0] r_in_phase;
    logic                         r_in_first;

    // Thresholds.
    logic [tspu_pkg::COARSE_W-1:0] r_coarse_thr;
    logic [tspu_pkg::FINE_W-1:0]   r_fine_thr;

    // History of the previous sample.
    logic [MIR_W-1:0]     r_last_mirrored;
    logic [ACC_WIDTH-1:0] r_last_coarse;
    logic [ACC_WIDTH-1:0] r_last_fine;

    // Result register.
    logic             r_out_valid;
    logic [OUT_W-1:0] r_out_fine;
    logic [OUT_W-1:0] r_out_coarse;

    logic                     w_adv;
    logic                     w_fire;
    logic signed [WIDE_W-1:0] w_phase;
    logic signed [WIDE_W-1:0] w_phase_sat;
    logic signed [WIDE_W-1:0] w_mirrored;
    logic signed [WIDE_W-1:0] w_mprev;
    logic signed [WIDE_W-1:0] w_cprev;
    logic signed [WIDE_W-1:0] w_fprev;
    logic signed [WIDE_W-1:0] w_cstep;
    logic signed [WIDE_W-1:0] w_fstep;
    logic signed [WIDE_W-1:0] w_coarse_lim;
    logic signed [WIDE_W-1:0] w_fine_lim;
    logic signed [WIDE_W-1:0] w_coarse;
    logic signed [WIDE_W-1:0] w_fine;

    // The result register moves when it is empty or being drained.
    assign w_adv      = !r_out_valid || i_m_tready;
    assign w_fire     = r_in_valid && w_adv;
    assign o_s_tready = !r_in_valid || w_adv;

    // Mirror the clamped phase to a full turn minus the sample.
    assign w_phase     = $signed({{(WIDE_W-tspu_pkg::PHASE_W){1'b0}}, r_in_phase});
    assign w_phase_sat = (w_phase > PHASE_MAX) ? PHASE_MAX : w_phase;
    assign w_mirrored  = FULL_V - w_phase_sat;

    // A new sequence starts from an all-zero history with corrections off.
    assign w_mprev = r_in_first ? '0 : $signed({{(WIDE_W-MIR_W){1'b0}}, r_last_mirrored});
    assign w_cprev = r_in_first ? '0 :
        $signed({{(WIDE_W-ACC_WIDTH){r_last_coarse[ACC_WIDTH-1]}}, r_last_coarse});
    assign w_fprev = r_in_first ? '0 :
        $signed({{(WIDE_W-ACC_WIDTH){r_last_fine[ACC_WIDTH-1]}}, r_last_fine});

    assign w_cstep = w_mirrored - w_mprev;
    assign w_fstep = w_coarse - w_cprev;

    assign w_coarse_lim = $signed({{(WIDE_W-tspu_pkg::COARSE_W){1'b0}}, r_coarse_thr});
    assign w_fine_lim   = $signed({{(WIDE_W-tspu_pkg::FINE_W){1'b0}}, r_fine_thr});

    tspu_stage #(
        .WIDE_W    (WIDE_W),
        .ACC_WIDTH (ACC_WIDTH)
    ) u_coarse (
        .i_prev   (w_cprev),
        .i_step   (w_cstep),
        .i_limit  (w_coarse_lim),
        .i_turn   (FULL_V),
        .i_bypass (r_in_first),
        .o_out    (w_coarse)
    );

    tspu_stage #(
        .WIDE_W    (WIDE_W),
        .ACC_WIDTH (ACC_WIDTH)
    ) u_fine (
        .i_prev   (w_fprev),
        .i_step   (w_fstep),
        .i_limit  (w_fine_lim),
        .i_turn   (HALF_V),
        .i_bypass (r_in_first),
        .o_out    (w_fine)
    );

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coarse_thr <= tspu_pkg::COARSE_RST;
            r_fine_thr   <= tspu_pkg::FINE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                tspu_pkg::REG_COARSE: r_coarse_thr <= i_cfg_wdata[tspu_pkg::COARSE_W-1:0];
                tspu_pkg::REG_FINE:   r_fine_thr   <= i_cfg_wdata[tspu_pkg::FINE_W-1:0];
                default: ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
        if (i_s_tvalid && o_s_tready) begin
            r_in_phase <= i_s_tdata;
            r_in_first <= i_s_tuser;
        end
    end

    // History and result register update together.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid     <= 1'b0;
            r_last_mirrored <= '0;
            r_last_coarse   <= '0;
            r_last_fine     <= '0;
        end else begin
            if (w_adv) begin
                r_out_valid <= r_in_valid;
            end
            if (w_fire) begin
                r_last_mirrored <= w_mirrored[MIR_W-1:0];
                r_last_coarse   <= w_coarse[ACC_WIDTH-1:0];
                r_last_fine     <= w_fine[ACC_WIDTH-1:0];
            end
        end
        if (w_fire) begin
            r_out_fine   <= w_fine[OUT_W-1:0];
            r_out_coarse <= w_coarse[OUT_W-1:0];
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_coarse, r_out_fine};

`ifndef SYNTH
    logic signed [WIDE_W-1:0] w_chk_coarse;
    assign w_chk_coarse =
        $signed({{(WIDE_W-ACC_WIDTH){r_last_coarse[ACC_WIDTH-1]}}, r_last_coarse});

    // A sample that opens a sequence leaves both stages with the same value.
    a_first_equal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_in_first) |=> (o_m_tdata[OUT_W-1:0] == o_m_tdata[2*OUT_W-1:OUT_W]))
        else $error("first sample gave different coarse and fine results");

    // The pending coarse result always matches the stored coarse history.
    a_hist_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (w_chk_coarse[OUT_W-1:0] == r_out_coarse))
        else $error("coarse history out of step with the result register");

    // An empty result register never blocks the input side.
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> o_s_tready)
        else $error("input stalled while the result register is empty");

    // Without a transaction in flight the history does not move.
    a_hist_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_fire |=> ($stable(r_last_coarse) && $stable(r_last_fine)))
        else $error("history changed without a processed transaction");
`endif

endmodule

/* rtl/tspu_stage.sv */
// One unwrap stage: adds a step, corrects a turn jump and saturates the sum.
module tspu_stage #(
    parameter int WIDE_W    = 36,
    parameter int ACC_WIDTH = 32
) (
    input  logic signed [WIDE_W-1:0] i_prev,
    input  logic signed [WIDE_W-1:0] i_step,
    input  logic signed [WIDE_W-1:0] i_limit,
    input  logic signed [WIDE_W-1:0] i_turn,
    input  logic                     i_bypass,
    output logic signed [WIDE_W-1:0] o_out
);

    localparam logic signed [WIDE_W-1:0] ACC_MAX =
        {{(WIDE_W-ACC_WIDTH+1){1'b0}}, {(ACC_WIDTH-1){1'b1}}};
    localparam logic signed [WIDE_W-1:0] ACC_MIN = ~ACC_MAX;

    logic signed [WIDE_W-1:0] w_sum;
    logic signed [WIDE_W-1:0] w_corr;

    assign w_sum = i_prev + i_step;

    // A step exactly at the limit, or at its negative, is left alone.
    always_comb begin
        if (!i_bypass && (i_step > i_limit)) begin
            w_corr = w_sum - i_turn;
        end else if (!i_bypass && (i_step < -i_limit)) begin
            w_corr = w_sum + i_turn;
        end else begin
            w_corr = w_sum;
        end
    end

    assign o_out = (w_corr > ACC_MAX) ? ACC_MAX :
                   (w_corr < ACC_MIN) ? ACC_MIN : w_corr;

endmodule
